FILE: hw/rtl/mdt_pkg.sv
// Shared types, constants and helpers for the multi-slot deadline timer.
`default_nettype none

package mdt_pkg;

    localparam int SLOTS_DEF      = 16;
    localparam int MAX_FIRES      = 16;
    localparam int SLOTS_IN_USE_RST = 16;
    localparam int PADDR_W        = 3;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 40;

    // Register word index on the APB port
    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_TICK  = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic        active;
        logic [31:0] due;
    } slot_t;

    // Control from the head of the ring to the cells
    typedef struct packed {
        logic  shift;
        slot_t fill;
    } ring_ctl_t;

    // Wraparound-safe test: the due time has been reached at time now
    function automatic logic reached(input logic [31:0] now, input logic [31:0] due);
        logic [31:0] diff;
        diff = now - due;
        return !diff[31];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mdt_cell.sv
// One timer slot cell of the rotating ring.
`default_nettype none

module mdt_cell
    import mdt_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  shift,
    input  wire slot_t d,
    output slot_t      q
);

    slot_t slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (shift) begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mdt_head.sv
// Request sequencer: processes the slot at the head of the ring and drives results.
`default_nettype none

module mdt_head
    import mdt_pkg::*;
#(
    parameter  int SLOTS = SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel: tuser = req_type; tdata = slot_id[7:0], delay_ticks[39:8]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [1:0]           s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [4:0]           slots_in_use,
    input  wire slot_t                head,
    output ring_ctl_t                 ring,
    // result channel: tuser = fired_valid;
    // tdata = fired_id[3:0], rejected[4], have_due[5], next_delay[37:6], zero[39:38]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      m_tuser,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast
);

    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [7:0]  id_reg;
    logic [31:0] due_start_reg;
    logic [31:0] now_reg;
    logic [4:0]  cnt_reg;
    logic        rej_reg;
    logic [IDX_W-1:0] step_reg;
    logic [4:0]  fires_reg;
    logic        have_reg;
    logic [31:0] cand_reg;

    logic        out_valid_reg;
    logic        out_fired_reg;
    logic [3:0]  out_id_reg;
    logic        out_rej_reg;
    logic        out_have_reg;
    logic [31:0] out_nd_reg;
    logic        out_last_reg;

    logic        accept;
    logic [4:0]  eff_cnt;
    logic        out_free;
    logic        in_range;
    logic        hit;
    logic        fire;
    logic        advance;
    logic        last_step;
    logic        take;
    logic        sum_load;
    logic [31:0] nd_sum;
    slot_t       slot_new;

    // Clamp the configured count to the ring length
    assign eff_cnt  = (7'(slots_in_use) < 7'(SLOTS)) ? slots_in_use : 5'(SLOTS);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign in_range  = 8'(step_reg) < 8'(cnt_reg);
    assign hit       = in_range && (8'(step_reg) == id_reg);
    assign last_step = step_reg == IDX_W'(SLOTS - 1);

    assign fire = (state_reg == ST_SCAN) && (req_reg == REQ_TICK) && in_range &&
                  head.active && reached(now_reg, head.due) &&
                  (fires_reg < 5'(MAX_FIRES));

    // Hold the ring while a fired result cannot be placed
    assign advance = (state_reg == ST_SCAN) && !(fire && !out_free);

    always_comb begin
        slot_new = head;
        if (req_reg == REQ_START && hit) begin
            slot_new.active = 1'b1;
            slot_new.due    = due_start_reg;
        end
        if ((req_reg == REQ_STOP && hit) || fire) begin
            slot_new.active = 1'b0;
        end
    end

    // Later slot wins a tie
    assign take = in_range && slot_new.active &&
                  (!have_reg || reached(cand_reg, slot_new.due));

    assign nd_sum   = (have_reg && !reached(now_reg, cand_reg)) ? (cand_reg - now_reg) : '0;
    assign sum_load = (state_reg == ST_SUM) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (advance && last_step) state_next = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        ring.shift = advance;
        ring.fill  = slot_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            step_reg      <= '0;
            fires_reg     <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (req_t'(s_tuser) == REQ_TICK) now_reg <= now_reg + 32'd1;
                step_reg  <= '0;
                fires_reg <= '0;
                have_reg  <= 1'b0;
            end else if (advance) begin
                step_reg <= last_step ? '0 : step_reg + 1'b1;
                if (fire) fires_reg <= fires_reg + 5'd1;
                if (take) have_reg <= 1'b1;
            end
            if ((fire && advance) || sum_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg       <= req_t'(s_tuser);
            id_reg        <= s_tdata[7:0];
            due_start_reg <= now_reg + s_tdata[39:8];
            cnt_reg       <= eff_cnt;
            rej_reg       <= (s_tuser inside {REQ_START, REQ_STOP}) &&
                             (s_tdata[7:0] >= 8'(eff_cnt));
        end
        if (advance && take) cand_reg <= slot_new.due;
        if (fire && advance) begin
            out_fired_reg <= 1'b1;
            out_id_reg    <= 4'(step_reg);
            out_rej_reg   <= 1'b0;
            out_have_reg  <= 1'b0;
            out_nd_reg    <= '0;
            out_last_reg  <= 1'b0;
        end else if (sum_load) begin
            out_fired_reg <= 1'b0;
            out_id_reg    <= '0;
            out_rej_reg   <= rej_reg;
            out_have_reg  <= have_reg;
            out_nd_reg    <= nd_sum;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_fired_reg;
    assign m_tdata  = {2'b00, out_nd_reg, out_have_reg, out_rej_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    a_ring_home: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (step_reg == '0))
        else $error("ring not back in place when idle");

    a_fire_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        fires_reg <= 5'(MAX_FIRES))
        else $error("too many expiries in one tick");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !advance) |=> ($stable(step_reg) && state_reg == ST_SCAN))
        else $error("ring moved while a fired result was blocked");

    a_fire_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && advance) |-> (req_reg == REQ_TICK && out_free))
        else $error("expiry outside a tick or into a full output register");

endmodule

`default_nettype wire

FILE: hw/rtl/multi_slot_deadline_timer_top.sv
// Top level of the multi-slot deadline timer: APB register, slot ring and sequencer.
//
// Usage: requests enter on the s_ stream (tuser = request kind: start, stop, tick;
// tdata = slot id and delay). Each request yields zero or more expiry results
// (m_tuser high, one per fired slot in slot order) followed by one summary result
// with m_tlast high, carrying the reject flag and the delay to the earliest deadline.
// The slots sit in a ring of SLOTS cells that rotates one place per cycle past a
// single processing head during a scan, unless a stall holds it. The summary is
// loaded once the ring has passed all SLOTS cells, and the next request is taken
// once the summary is in the output register, so no new request is taken before
// the last one is summarised. A stalled receiver holds the ring whenever an expiry
// result is waiting for space, and holds the sequencer before the summary.
// The APB register slots_in_use (byte address 0) limits which slots are addressed and
// scanned; write it only while the block is idle. Reset clears the tick clock, all
// slots and the output register, and sets slots_in_use to 16; no clearing pass runs.
`default_nettype none

module multi_slot_deadline_timer_top
    import mdt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // tuser = req_type[1:0]
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [1:0]           s_tuser,
    // tdata = slot_id[7:0], delay_ticks[39:8]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // tuser = fired_valid
    output logic                      m_tuser,
    // tdata = fired_id[3:0], rejected[4], have_due[5], next_delay[37:6], zero[39:38]
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tlast,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [4:0] slots_in_use_reg;
    logic       reg_sel;
    ring_ctl_t  ring;
    slot_t      cell_q [SLOTS];

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1:2] == REG_SLOTS_IN_USE;
    assign prdata  = reg_sel ? 32'(slots_in_use_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= 5'(SLOTS_IN_USE_RST);
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            slots_in_use_reg <= pwdata[4:0];
        end
    end

    // Rotate towards cell 0; the head's processed slot re-enters at the far end
    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        slot_t cell_d;
        if (i == SLOTS - 1) begin : g_tail
            assign cell_d = ring.fill;
        end else begin : g_mid
            assign cell_d = cell_q[i + 1];
        end
        mdt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift   (ring.shift),
            .d       (cell_d),
            .q       (cell_q[i])
        );
    end

    mdt_head #(
        .SLOTS (SLOTS)
    ) u_head (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .slots_in_use (slots_in_use_reg),
        .head         (cell_q[0]),
        .ring         (ring),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tuser      (m_tuser),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire
